@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the drive arbiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cad_pkg.sv @@
// Shared types, field layout and codes of the collision-avoidance drive arbiter.
`timescale 1ns / 1ps

package cad_pkg;

    // Input word layout (tdata), lowest bit first.
    localparam int InTdataW    = 88;
    localparam int InNowLo     = 0;
    localparam int InAxLo      = 32;
    localparam int InAyLo      = 48;
    localparam int InEchoLo    = 64;
    localparam int InCrashBit  = 79;
    localparam int InObstBit   = 80;
    localparam int InDirLo     = 81;

    // Output word layout (tdata), lowest bit first.
    localparam int OutTdataW   = 48;
    localparam int OutScnLo    = 0;
    localparam int OutMsgLo    = 3;
    localparam int OutSpeedLo  = 5;
    localparam int OutSteerLo  = 13;
    localparam int OutLpwmLo   = 15;
    localparam int OutRpwmLo   = 23;
    localparam int OutBrakeBit = 31;
    localparam int OutEmergBit = 32;
    localparam int OutOwnBit   = 33;
    localparam int OutPlatBit  = 34;
    localparam int OutDistLo   = 35;
    localparam int OutZoneLo   = 45;

    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 16;

    typedef enum logic [CfgAddrW-1:0] {
        REG_CRASH_LIMIT  = 3'd0,
        REG_CRITICAL_CM  = 3'd1,
        REG_DANGER_CM    = 3'd2,
        REG_WARNING_CM   = 3'd3,
        REG_LINK_TIMEOUT = 3'd4,
        REG_SLOW_SPEED   = 3'd5,
        REG_MEDIUM_SPEED = 3'd6,
        REG_FAST_SPEED   = 3'd7
    } t_cfg_reg;

    // Register reset values.
    localparam logic [14:0] RstCrashLimit = 15'd12000;
    localparam logic [8:0]  RstCriticalCm = 9'd11;
    localparam logic [8:0]  RstDangerCm   = 9'd20;
    localparam logic [8:0]  RstWarningCm  = 9'd50;
    localparam logic [15:0] RstLinkTmo    = 16'd2000;
    localparam logic [7:0]  RstSlowSpeed  = 8'd80;
    localparam logic [7:0]  RstMedSpeed   = 8'd160;
    localparam logic [7:0]  RstFastSpeed  = 8'd220;

    // Scenario codes.
    localparam logic [2:0] ScnCollision = 3'd1;
    localparam logic [2:0] ScnSlowDown  = 3'd2;
    localparam logic [2:0] ScnCrash     = 3'd3;
    localparam logic [2:0] ScnObstacle  = 3'd4;
    localparam logic [2:0] ScnPlatoon   = 3'd5;

    // Message kinds.
    localparam logic [1:0] MsgNormal    = 2'd1;
    localparam logic [1:0] MsgWarning   = 2'd2;
    localparam logic [1:0] MsgEmergency = 2'd3;

    // Zones.
    localparam logic [1:0] ZoneSafe     = 2'd0;
    localparam logic [1:0] ZoneWarning  = 2'd1;
    localparam logic [1:0] ZoneDanger   = 2'd2;
    localparam logic [1:0] ZoneCritical = 2'd3;

    // Steering codes (two's complement).
    localparam logic [1:0] SteerStraight = 2'b00;
    localparam logic [1:0] SteerRight    = 2'b01;
    localparam logic [1:0] SteerLeft     = 2'b11;

    // Distance conversion: cm = echo_us * 17 / 1000.
    localparam logic [9:0]  DistFar       = 10'd999;
    localparam logic [19:0] ScaledMax     = 20'd400000;
    // floor(x / 1000) == (x * RecipMul) >> RecipShift for every x up to ScaledMax.
    localparam int          RecipShift    = 28;
    localparam logic [18:0] RecipMul      = 19'd268436;

endpackage

@@ hdl/collision_avoid_drive_arbiter.sv @@
// Top level of the collision-avoidance drive arbiter.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         i_s_axis_tvalid/o_..._tready  tdata: sensor or peer word, tuser: opcode
// m_axis    out        o_m_axis_tvalid/i_..._tready  tdata: drive decision word
// cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_addr register index, i_cfg_data
//
// One word is accepted per cycle while the input side is not stalled. A control word is
// registered in the input register and its decision is then registered in the output
// register. Peer words update the link state and produce no output. The input side stalls
// only while a control word waits behind an output word that is not taken. Reset is
// synchronous, active low, and restores the register defaults and clears the peer state.

module collision_avoid_drive_arbiter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: now_ms[31:0], accel_x[47:32], accel_y[63:48], echo_us[78:64],
    // peer_crash[79], peer_obstacle[80], peer_direction[82:81], zero[87:83]
    input  logic [cad_pkg::InTdataW-1:0]   i_s_axis_tdata,
    // tuser: opcode[0]
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata: scenario[2:0], message_kind[4:3], speed[12:5], steer[14:13],
    // left_pwm[22:15], right_pwm[30:23], braking[31], emergency[32], own_crash[33],
    // platoon[34], range_cm[44:35], zone[46:45], zero[47]
    output logic [cad_pkg::OutTdataW-1:0]  o_m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cad_pkg::CfgAddrW-1:0]   i_cfg_addr,
    input  logic [cad_pkg::CfgDataW-1:0]   i_cfg_data
);
    import cad_pkg::*;

    // Configuration registers.
    logic [14:0] r_crash_limit;
    logic [8:0]  r_critical_cm;
    logic [8:0]  r_danger_cm;
    logic [8:0]  r_warning_cm;
    logic [15:0] r_link_tmo;
    logic [7:0]  r_slow_speed;
    logic [7:0]  r_med_speed;
    logic [7:0]  r_fast_speed;

    // Peer state.
    logic [31:0] r_peer_last;
    logic        r_peer_seen;
    logic        r_peer_crash;
    logic        r_peer_obst;
    logic [1:0]  r_peer_dir;

    // Input register.
    logic        r_s1_valid;
    logic        r_s1_op;
    logic [31:0] r_s1_now;
    logic [15:0] r_s1_ax;
    logic [15:0] r_s1_ay;
    logic [14:0] r_s1_echo;
    logic        r_s1_pcrash;
    logic        r_s1_pobst;
    logic [1:0]  r_s1_pdir;

    // Output register.
    logic                 r_out_valid;
    logic [OutTdataW-1:0] r_out_data;
    logic [OutTdataW-1:0] n_out_data;

    logic w_out_free;
    logic w_s1_go;
    logic w_s_accept;

    logic [19:0] w_scaled;
    logic        w_far;
    logic [38:0] w_prod;
    logic [9:0]  w_dist;
    logic [1:0]  w_zone;
    logic [31:0] w_age;
    logic        w_live;
    logic        w_own;

    logic [2:0] n_scn;
    logic [1:0] n_msg;
    logic [7:0] n_spd;
    logic [1:0] n_steer;
    logic [7:0] n_lp;
    logic [7:0] n_rp;
    logic       n_brake;
    logic       n_emerg;
    logic       n_plat;

    function automatic logic [19:0] cm_to_scaled(input logic [8:0] cm);
        return 20'(cm) * 20'd1000;
    endfunction

    function automatic logic [16:0] abs16(input logic [15:0] v);
        logic [16:0] ext;
        ext = {v[15], v};
        return v[15] ? (17'd0 - ext) : ext;
    endfunction

    // Handshake.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_s1_go         = r_s1_valid && (r_s1_op || w_out_free);
    assign o_s_axis_tready = !r_s1_valid || w_s1_go;
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    // Distance and zone.
    assign w_scaled = 20'({r_s1_echo, 4'd0}) + 20'(r_s1_echo);
    assign w_far    = (r_s1_echo == 15'd0) || (w_scaled > ScaledMax);
    assign w_prod   = 39'(w_scaled) * 39'(RecipMul);
    assign w_dist   = w_far ? DistFar : w_prod[RecipShift +: 10];

    always_comb begin
        if (w_far) begin
            w_zone = ZoneSafe;
        end else if (w_scaled <= cm_to_scaled(r_critical_cm)) begin
            w_zone = ZoneCritical;
        end else if (w_scaled <= cm_to_scaled(r_danger_cm)) begin
            w_zone = ZoneDanger;
        end else if (w_scaled <= cm_to_scaled(r_warning_cm)) begin
            w_zone = ZoneWarning;
        end else begin
            w_zone = ZoneSafe;
        end
    end

    // Link liveness uses the wrapping age of the last peer word.
    assign w_age  = r_s1_now - r_peer_last;
    assign w_live = r_peer_seen && (w_age < 32'(r_link_tmo));
    assign w_own  = (abs16(r_s1_ax) > 17'(r_crash_limit))
                 || (abs16(r_s1_ay) > 17'(r_crash_limit));

    // Priority pick.
    always_comb begin
        n_scn   = ScnPlatoon;
        n_msg   = MsgNormal;
        n_spd   = r_fast_speed;
        n_steer = SteerStraight;
        n_lp    = r_fast_speed;
        n_rp    = r_fast_speed;
        n_brake = 1'b0;
        n_emerg = 1'b0;
        n_plat  = 1'b1;
        if (w_own || (w_live && r_peer_crash)) begin
            n_scn   = ScnCrash;
            n_msg   = MsgEmergency;
            n_spd   = 8'd0;
            n_lp    = 8'd0;
            n_rp    = 8'd0;
            n_brake = 1'b1;
            n_emerg = 1'b1;
            n_plat  = 1'b0;
        end else if (w_zone == ZoneCritical) begin
            n_scn   = ScnCollision;
            n_msg   = MsgEmergency;
            n_spd   = 8'd0;
            n_lp    = 8'd0;
            n_rp    = 8'd0;
            n_brake = 1'b1;
            n_emerg = 1'b1;
            n_plat  = 1'b0;
        end else if (w_live && r_peer_obst) begin
            n_scn  = ScnObstacle;
            n_msg  = MsgWarning;
            n_spd  = r_med_speed;
            n_plat = 1'b0;
            // Only an explicit right turn goes right; every other pattern turns left.
            if (r_peer_dir == SteerRight) begin
                n_steer = SteerRight;
                n_lp    = r_med_speed;
                n_rp    = {1'b0, r_med_speed[7:1]};
            end else begin
                n_steer = SteerLeft;
                n_lp    = {1'b0, r_med_speed[7:1]};
                n_rp    = r_med_speed;
            end
        end else if (w_zone == ZoneDanger) begin
            n_scn  = ScnSlowDown;
            n_msg  = MsgWarning;
            n_spd  = r_slow_speed;
            n_lp   = r_slow_speed;
            n_rp   = r_slow_speed;
            n_plat = 1'b0;
        end else if (w_zone == ZoneWarning) begin
            n_scn  = ScnSlowDown;
            n_msg  = MsgWarning;
            n_spd  = r_med_speed;
            n_lp   = r_med_speed;
            n_rp   = r_med_speed;
            n_plat = 1'b0;
        end
    end

    assign n_out_data = {1'b0, w_zone, w_dist, n_plat, w_own, n_emerg, n_brake,
                         n_rp, n_lp, n_steer, n_spd, n_msg, n_scn};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_peer_last   <= 32'd0;
            r_peer_seen   <= 1'b0;
            r_peer_crash  <= 1'b0;
            r_peer_obst   <= 1'b0;
            r_peer_dir    <= SteerStraight;
            r_crash_limit <= RstCrashLimit;
            r_critical_cm <= RstCriticalCm;
            r_danger_cm   <= RstDangerCm;
            r_warning_cm  <= RstWarningCm;
            r_link_tmo    <= RstLinkTmo;
            r_slow_speed  <= RstSlowSpeed;
            r_med_speed   <= RstMedSpeed;
            r_fast_speed  <= RstFastSpeed;
        end else begin
            if (o_s_axis_tready) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= w_s1_go && !r_s1_op;
            end
            if (w_s1_go && r_s1_op) begin
                r_peer_last  <= r_s1_now;
                r_peer_seen  <= 1'b1;
                r_peer_crash <= r_s1_pcrash;
                r_peer_obst  <= r_s1_pobst;
                r_peer_dir   <= r_s1_pdir;
            end
            if (i_cfg_valid) begin
                case (t_cfg_reg'(i_cfg_addr))
                    REG_CRASH_LIMIT:  r_crash_limit <= i_cfg_data[14:0];
                    REG_CRITICAL_CM:  r_critical_cm <= i_cfg_data[8:0];
                    REG_DANGER_CM:    r_danger_cm   <= i_cfg_data[8:0];
                    REG_WARNING_CM:   r_warning_cm  <= i_cfg_data[8:0];
                    REG_LINK_TIMEOUT: r_link_tmo    <= i_cfg_data;
                    REG_SLOW_SPEED:   r_slow_speed  <= i_cfg_data[7:0];
                    REG_MEDIUM_SPEED: r_med_speed   <= i_cfg_data[7:0];
                    REG_FAST_SPEED:   r_fast_speed  <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_s1_op     <= i_s_axis_tuser;
            r_s1_now    <= i_s_axis_tdata[InNowLo +: 32];
            r_s1_ax     <= i_s_axis_tdata[InAxLo +: 16];
            r_s1_ay     <= i_s_axis_tdata[InAyLo +: 16];
            r_s1_echo   <= i_s_axis_tdata[InEchoLo +: 15];
            r_s1_pcrash <= i_s_axis_tdata[InCrashBit];
            r_s1_pobst  <= i_s_axis_tdata[InObstBit];
            r_s1_pdir   <= i_s_axis_tdata[InDirLo +: 2];
        end
        if (w_out_free && w_s1_go && !r_s1_op) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

@@ hdl/cad_checker.sv @@
// Port-level checks of the drive arbiter and their bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cad_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [cad_pkg::OutTdataW-1:0] o_m_axis_tdata
);
    import cad_pkg::*;

    logic       w_stall;
    logic       w_brake;
    logic       w_emerg;
    logic [7:0] w_speed;
    logic [9:0] w_dist;
    logic [1:0] w_zone;

    assign w_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_brake = o_m_axis_tdata[OutBrakeBit];
    assign w_emerg = o_m_axis_tdata[OutEmergBit];
    assign w_speed = o_m_axis_tdata[OutSpeedLo +: 8];
    assign w_dist  = o_m_axis_tdata[OutDistLo +: 10];
    assign w_zone  = o_m_axis_tdata[OutZoneLo +: 2];

    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_m_axis_tvalid, "output after reset")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall,
        o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled output word changed")
    `ASSERT_SAME(a_brake_stop, i_clk, i_rst_n, o_m_axis_tvalid && w_brake,
        (w_speed == 8'd0) && w_emerg, "braking word with nonzero speed")
    `ASSERT_SAME(a_far_safe, i_clk, i_rst_n, o_m_axis_tvalid && (w_dist == DistFar),
        w_zone == ZoneSafe, "out-of-range distance with a zone")
    `ASSERT_SAME(a_idle_ready, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready,
        "input held off with the output empty")

endmodule

bind collision_avoid_drive_arbiter cad_checker u_cad_checker (.*);
